FILE: src/dna_barcode_nearest_match_assert.svh
// assertion macros for the barcode match block
`ifndef DNA_BARCODE_NEAREST_MATCH_ASSERT_SVH
`define DNA_BARCODE_NEAREST_MATCH_ASSERT_SVH

`ifndef SYNTHESIS
`define DBNM_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define DBNM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define DBNM_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define DBNM_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

FILE: src/dbnm_pkg.sv
package dbnm_pkg;

   localparam int unsigned DEF_MAX_ENTRIES = 512;
   localparam int unsigned DEF_MAX_BASES   = 16;
   localparam int unsigned LANE_BITS       = 2;
   localparam int unsigned LANES           = 1 << LANE_BITS;

   localparam logic [4:0] RESET_LENGTH    = 5'd8;
   localparam logic [4:0] RESET_MISMATCH  = 5'd1;
   localparam logic [4:0] RESET_AMBIGUOUS = 5'd0;
   localparam logic [3:0] N_MASK          = 4'hF;

   typedef enum logic [1:0] {
      CSR_LENGTH    = 2'd0,
      CSR_MISMATCH  = 2'd1,
      CSR_AMBIGUOUS = 2'd2
   } csr_index_type;

   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_QUERY = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      RS_LOADED   = 2'd0,
      RS_FULL     = 2'd1,
      RS_MATCH    = 2'd2,
      RS_NO_MATCH = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [LANES-1:0]      valid;
      logic [LANES-1:0][4:0] mism;
   } lane_res_type;

endpackage

FILE: src/dbnm_lane.sv
module dbnm_lane #(
   parameter int unsigned ROWS  = 128,
   parameter int unsigned ROW_W = 7,
   parameter int unsigned BASES = 16
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ROW_W-1:0]   wr_row,
   input  logic [4*BASES-1:0] wr_data,
   input  logic               rd_en,
   input  logic [ROW_W-1:0]   rd_row,
   input  logic [4*BASES-1:0] query,
   input  logic [4:0]         len,
   output logic [4:0]         mism_ff
);
   import dbnm_pkg::*;

   logic [4*BASES-1:0] mem [ROWS];
   logic [4*BASES-1:0] rd_data_ff;
   logic [4:0]         mism_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
      end
   end

   always_comb begin
      mism_in = '0;
      for (int i = 0; i < BASES; i++) begin
         if ((5'(i) < len) && ((query[4*i +: 4] & rd_data_ff[4*i +: 4]) == 4'b0)) begin
            mism_in = mism_in + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mism_ff <= mism_in;
   end

endmodule

FILE: src/dbnm_merge.sv
module dbnm_merge #(
   parameter int unsigned ROW_W = 7
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [5:0]                     init_best,
   input  logic                           in_valid,
   input  logic [ROW_W-1:0]               in_row,
   input  dbnm_pkg::lane_res_type         lane_res,
   output logic                           found_ff,
   output logic [5:0]                     best_ff,
   output logic [ROW_W+dbnm_pkg::LANE_BITS-1:0] best_idx_ff
);
   import dbnm_pkg::*;

   logic                      found_in;
   logic [5:0]                best_in;
   logic [ROW_W+LANE_BITS-1:0] best_idx_in;

   // lanes in order, strict less keeps the first entry on a tie
   always_comb begin
      found_in    = found_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      for (int l = 0; l < LANES; l++) begin
         if (lane_res.valid[l] && ({1'b0, lane_res.mism[l]} < best_in)) begin
            found_in    = 1'b1;
            best_in     = {1'b0, lane_res.mism[l]};
            best_idx_in = {in_row, LANE_BITS'(l)};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (start) begin
         found_ff    <= 1'b0;
         best_ff     <= init_best;
      end else if (in_valid) begin
         found_ff    <= found_in;
         best_ff     <= best_in;
         best_idx_ff <= best_idx_in;
      end
   end

endmodule

FILE: src/dna_barcode_nearest_match.sv
// load word: result goes through res and rsp, next word accepted back in idle
// query word: rows scanned, result through res and rsp, next word accepted back in idle
// a query against an empty table or with too many n bases answers without a scan
// a held rsp word keeps the next result in the finish state and stalls the input
// reset clears the entry count and loads the register defaults
// table contents are not cleared and are only read below the entry count
`include "dna_barcode_nearest_match_assert.svh"

module dna_barcode_nearest_match #(
   parameter int unsigned MAX_ENTRIES = dbnm_pkg::DEF_MAX_ENTRIES,
   parameter int unsigned MAX_BASES   = dbnm_pkg::DEF_MAX_BASES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // base_masks
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // entry_index, mismatches, zero pad
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [4:0]  csr_wdata
);
   import dbnm_pkg::*;

   localparam int unsigned QW    = 4 * MAX_BASES;
   localparam int unsigned ROWS  = (MAX_ENTRIES + LANES - 1) / LANES;
   localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned IDX_W = ROW_W + LANE_BITS;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [4:0]         blen_ff, blen_in;
   logic [4:0]         mlim_ff, mlim_in;
   logic [4:0]         alim_ff, alim_in;
   logic [QW-1:0]      query_ff, query_in;
   logic [4:0]         len_ff, len_in;
   logic [ROW_W-1:0]   last_row_ff, last_row_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               issuing_ff, issuing_in;
   logic               s1_valid_ff, s1_valid_in;
   logic [ROW_W-1:0]   s1_row_ff, s1_row_in;
   logic               s2_valid_ff, s2_valid_in;
   logic [ROW_W-1:0]   s2_row_ff, s2_row_in;
   logic [LANES-1:0]   s2_mask_ff, s2_mask_in;
   status_type         res_status_ff, res_status_in;
   logic [8:0]         res_idx_ff, res_idx_in;
   logic [4:0]         res_mism_ff, res_mism_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [8:0]         rsp_idx_ff, rsp_idx_in;
   logic [4:0]         rsp_mism_ff, rsp_mism_in;

   logic               accept;
   logic               load_ok;
   logic [4:0]         len_req;
   logic [4:0]         ncount;
   logic [31:0]        count_ext;
   logic [LANES-1:0]   wr_en;
   logic [ROW_W-1:0]   wr_row;
   logic               rd_en;
   logic               merge_start;
   logic [5:0]         init_best;
   logic [LANES-1:0][4:0] lane_mism;
   lane_res_type       lane_res;
   logic               found;
   logic [5:0]         best;
   logic [IDX_W-1:0]   best_idx;

   assign count_ext  = 32'(count_ff);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign load_ok    = accept && (req_tuser == MODE_LOAD) && (count_ext < MAX_ENTRIES);
   assign wr_row     = ROW_W'(count_ext >> LANE_BITS);
   assign init_best  = {1'b0, mlim_ff} + 6'd1;
   assign len_req    = (32'(blen_ff) > MAX_BASES) ? 5'(MAX_BASES) : blen_ff;
   assign rd_en      = (state_ff == ST_SCAN) && issuing_ff;

   always_comb begin
      ncount = '0;
      for (int i = 0; i < MAX_BASES; i++) begin
         if ((5'(i) < len_req) && (req_tdata[4*i +: 4] == N_MASK)) begin
            ncount = ncount + 5'd1;
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         wr_en[l] = load_ok && (count_ext[LANE_BITS-1:0] == LANE_BITS'(l));
      end
   end

   genvar g;
   generate
      for (g = 0; g < LANES; g++) begin : g_lane
         dbnm_lane #(
            .ROWS  (ROWS),
            .ROW_W (ROW_W),
            .BASES (MAX_BASES)
         ) u_lane (
            .clock   (clock),
            .wr_en   (wr_en[g]),
            .wr_row  (wr_row),
            .wr_data (req_tdata[QW-1:0]),
            .rd_en   (rd_en),
            .rd_row  (row_ff),
            .query   (query_ff),
            .len     (len_ff),
            .mism_ff (lane_mism[g])
         );
      end
   endgenerate

   assign lane_res.valid = s2_mask_ff;
   assign lane_res.mism  = lane_mism;

   dbnm_merge #(
      .ROW_W (ROW_W)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .start       (merge_start),
      .init_best   (init_best),
      .in_valid    (s2_valid_ff),
      .in_row      (s2_row_ff),
      .lane_res    (lane_res),
      .found_ff    (found),
      .best_ff     (best),
      .best_idx_ff (best_idx)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      blen_in       = blen_ff;
      mlim_in       = mlim_ff;
      alim_in       = alim_ff;
      query_in      = query_ff;
      len_in        = len_ff;
      last_row_in   = last_row_ff;
      row_in        = row_ff;
      issuing_in    = issuing_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_mism_in   = res_mism_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_mism_in   = rsp_mism_ff;
      merge_start   = 1'b0;

      s1_valid_in = rd_en;
      s1_row_in   = row_ff;
      s2_valid_in = s1_valid_ff;
      s2_row_in   = s1_row_ff;
      for (int l = 0; l < LANES; l++) begin
         s2_mask_in[l] = s1_valid_ff &&
            (((32'(s1_row_ff) << LANE_BITS) + 32'(l)) < count_ext);
      end

      if (csr_we) begin
         case (csr_addr)
            CSR_LENGTH:    blen_in = csr_wdata;
            CSR_MISMATCH:  mlim_in = csr_wdata;
            CSR_AMBIGUOUS: alim_in = csr_wdata;
            default:       ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_idx_in  = '0;
               res_mism_in = '0;
               state_in    = ST_FINISH;
               if (req_tuser == MODE_LOAD) begin
                  if (load_ok) begin
                     res_status_in = RS_LOADED;
                     res_idx_in    = count_ext[8:0];
                     count_in      = CNT_W'(count_ext + 32'd1);
                  end else begin
                     res_status_in = RS_FULL;
                  end
               end else begin
                  res_status_in = RS_NO_MATCH;
                  query_in      = req_tdata[QW-1:0];
                  len_in        = len_req;
                  if ((ncount <= alim_ff) && (count_ff != '0)) begin
                     merge_start = 1'b1;
                     row_in      = '0;
                     issuing_in  = 1'b1;
                     last_row_in = ROW_W'((count_ext - 32'd1) >> LANE_BITS);
                     state_in    = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (issuing_ff) begin
               if (row_ff == last_row_ff) begin
                  issuing_in = 1'b0;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else if (!s1_valid_ff && !s2_valid_ff) begin
               if (found) begin
                  res_status_in = RS_MATCH;
                  res_idx_in    = 9'(32'(best_idx));
                  res_mism_in   = best[4:0];
               end else begin
                  res_status_in = RS_NO_MATCH;
                  res_idx_in    = '0;
                  res_mism_in   = '0;
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_idx_in    = res_idx_ff;
               rsp_mism_in   = res_mism_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
      end else begin
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         blen_ff      <= RESET_LENGTH;
         mlim_ff      <= RESET_MISMATCH;
         alim_ff      <= RESET_AMBIGUOUS;
         issuing_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s2_mask_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         blen_ff      <= blen_in;
         mlim_ff      <= mlim_in;
         alim_ff      <= alim_in;
         issuing_ff   <= issuing_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s2_mask_ff   <= s2_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff      <= query_in;
      len_ff        <= len_in;
      last_row_ff   <= last_row_in;
      row_ff        <= row_in;
      s1_row_ff     <= s1_row_in;
      s2_row_ff     <= s2_row_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_mism_ff   <= res_mism_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_mism_ff   <= rsp_mism_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_mism_ff, rsp_idx_ff};

   `DBNM_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ext <= MAX_ENTRIES)
   `DBNM_ASSERT_NEXT(a_load_counts, clock, reset, load_ok, count_ff == CNT_W'($past(count_ff) + 1'b1))
   `DBNM_ASSERT_IMPLY(a_match_limit, clock, reset, rsp_valid_ff && (rsp_status_ff == RS_MATCH), rsp_mism_ff <= mlim_ff)
   `DBNM_ASSERT_IMPLY(a_no_match_zero, clock, reset, rsp_valid_ff && (rsp_status_ff == RS_NO_MATCH), rsp_tdata == 16'd0)

endmodule
